// File: rtl/spectral_band_excision_mask_top_assert.svh
// Assertion macros for the spectral band excision mask.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef SPECTRAL_BAND_EXCISION_MASK_TOP_ASSERT_SVH
`define SPECTRAL_BAND_EXCISION_MASK_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SBEM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define SBEM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// An implication checked in the next cycle.
`define SBEM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sbem_pkg.sv
// Shared constants, register indexes and structs of the band excision mask.
// Used by every module of the block through scoped names.
package sbem_pkg;

   localparam int MAX_POINTS  = 4096;
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int FREQ_W      = 40;
   localparam int BW_W        = 34;
   localparam int OFF_W       = 36;
   localparam int EXT_W       = 42;
   localparam int FRAC_W      = 17;
   localparam int RESC_W      = 29;
   localparam int Q16_SHIFT   = 16;
   localparam int DIV_W       = CNT_W + Q16_SHIFT;
   localparam int STEP_W      = $clog2(DIV_W);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 40;

   localparam logic [RESC_W-1:0] RESCALE_MAX = {RESC_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_EXCLUDE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH    = 2'd2;

   typedef struct packed {
      logic              exclude_mode;
      logic [FREQ_W-1:0] band_low_hz;
      logic [FREQ_W-1:0] band_high_hz;
   } cfg_type;

   typedef struct packed {
      logic             keep;
      logic             last;
      logic             affected;
      logic             zero_all;
      logic [CNT_W-1:0] seen;
      logic [CNT_W-1:0] zeroed;
   } q_entry_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/sbem_front.sv
// Front end: accepts spectral points, forms the point and channel edges,
// classifies each point and keeps the per-channel counts. Uses sbem_pkg.
module sbem_front (
   input  logic                        clock,
   input  logic                        reset,
   input  sbem_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sbem_pkg::FREQ_W-1:0] sky_freq_hz,
   input  logic [sbem_pkg::BW_W-1:0]   chan_bandwidth_hz,
   input  logic                        lower_sideband,
   input  logic [sbem_pkg::OFF_W-1:0]  point_offset_hz,
   input  logic                        last_point,
   input  logic                        q_full,
   output logic                        q_push,
   output sbem_pkg::q_entry_type       q_entry
);

   localparam int EXT_W = sbem_pkg::EXT_W;
   localparam int CNT_W = sbem_pkg::CNT_W;

   logic signed [EXT_W-1:0] sky_s, bw_s, off_s, lo_s, hi_s;
   logic signed [EXT_W-1:0] f_in, ch_lo_in, ch_hi_in;
   logic signed [EXT_W-1:0] f_ff, ch_lo_ff, ch_hi_ff;
   logic                    s1_valid_ff, s1_valid_in, s1_last_ff;
   logic                    accept, overlap, zero;
   logic [CNT_W-1:0]        seen_ff, seen_in, zeroed_ff, zeroed_in;
   logic [CNT_W-1:0]        seen_next, zeroed_next;

   assign sky_s = signed'({{(EXT_W-sbem_pkg::FREQ_W){1'b0}}, sky_freq_hz});
   assign bw_s  = signed'({{(EXT_W-sbem_pkg::BW_W){1'b0}}, chan_bandwidth_hz});
   assign off_s = signed'({{(EXT_W-sbem_pkg::OFF_W){point_offset_hz[sbem_pkg::OFF_W-1]}},
                           point_offset_hz});
   assign lo_s  = signed'({{(EXT_W-sbem_pkg::FREQ_W){1'b0}}, cfg.band_low_hz});
   assign hi_s  = signed'({{(EXT_W-sbem_pkg::FREQ_W){1'b0}}, cfg.band_high_hz});

   assign req_ready = !s1_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = s1_valid_ff && !q_full;

   // First stage: the point frequency and the channel edges, at most one add or subtract each.
   always_comb begin
      if (lower_sideband) begin
         ch_lo_in = sky_s - bw_s;
         ch_hi_in = sky_s;
         f_in     = sky_s - off_s;
      end else begin
         ch_lo_in = sky_s;
         ch_hi_in = sky_s + bw_s;
         f_in     = sky_s + off_s;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Second stage: compares against the band and the count update.
   always_comb begin
      overlap = (ch_lo_ff <= hi_s) && (lo_s <= ch_hi_ff);
      if (cfg.exclude_mode) begin
         zero = overlap && (lo_s < f_ff) && (f_ff < hi_s);
      end else begin
         zero = !overlap || (f_ff < lo_s) || (f_ff > hi_s);
      end
      // Counts stop at the maximum; further points are judged but not counted.
      if (seen_ff < CNT_W'(sbem_pkg::MAX_POINTS)) begin
         seen_next   = seen_ff + 1'b1;
         zeroed_next = zeroed_ff + CNT_W'(zero);
      end else begin
         seen_next   = seen_ff;
         zeroed_next = zeroed_ff;
      end
      if (q_push && s1_last_ff) begin
         seen_in   = '0;
         zeroed_in = '0;
      end else if (q_push) begin
         seen_in   = seen_next;
         zeroed_in = zeroed_next;
      end else begin
         seen_in   = seen_ff;
         zeroed_in = zeroed_ff;
      end
      q_entry.keep     = !zero;
      q_entry.last     = s1_last_ff;
      q_entry.affected = overlap || !cfg.exclude_mode;
      q_entry.zero_all = !overlap && !cfg.exclude_mode;
      q_entry.seen     = seen_next;
      q_entry.zeroed   = zeroed_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         seen_ff     <= '0;
         zeroed_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         seen_ff     <= seen_in;
         zeroed_ff   <= zeroed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_ff       <= f_in;
         ch_lo_ff   <= ch_lo_in;
         ch_hi_ff   <= ch_hi_in;
         s1_last_ff <= last_point;
      end
   end

endmodule

// File: rtl/sbem_fifo.sv
// Short queue of classified points between the front and back ends.
// Entry type and depth come from sbem_pkg.
module sbem_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sbem_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output sbem_pkg::q_entry_type head,
   output logic                  full,
   output logic                  empty
);

   localparam int QPTR_W = sbem_pkg::QPTR_W;
   localparam int QCNT_W = sbem_pkg::QCNT_W;

   sbem_pkg::q_entry_type slots_ff [sbem_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(sbem_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(sbem_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(sbem_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/sbem_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Serves both end-of-channel ratios; widths from sbem_pkg.
module sbem_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sbem_pkg::div_req_type req,
   output sbem_pkg::div_rsp_type rsp
);

   localparam int DIV_W  = sbem_pkg::DIV_W;
   localparam int CNT_W  = sbem_pkg::CNT_W;
   localparam int STEP_W = sbem_pkg::STEP_W;

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   // The remainder stays below the divisor, so the shifted value fits CNT_W+1 bits.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, dvs_ff}) : trial[CNT_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: rtl/sbem_back.sv
// Back end: drains the queue, runs the end-of-channel divisions and drives
// the result register. Uses sbem_pkg and the sbem_div request structs.
module sbem_back (
   input  logic                                clock,
   input  logic                                reset,
   input  sbem_pkg::q_entry_type               head,
   input  logic                                q_empty,
   output logic                                q_pop,
   output sbem_pkg::div_req_type               div_req,
   input  sbem_pkg::div_rsp_type               div_rsp,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_last,
   output logic [sbem_pkg::RSP_DATA_W-1:0]     rsp_data
);

   localparam int CNT_W  = sbem_pkg::CNT_W;
   localparam int FRAC_W = sbem_pkg::FRAC_W;
   localparam int RESC_W = sbem_pkg::RESC_W;
   localparam int DATA_W = sbem_pkg::RSP_DATA_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FRAC = 4'b0010,
      ST_RESC = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic              keep_ff, keep_in, aff_ff, aff_in;
   logic [CNT_W-1:0]  seen_ff, seen_in, kept_ff, kept_in, head_kept;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [RESC_W-1:0] resc_ff, resc_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign head_kept = head.seen - head.zeroed;

   always_comb begin
      state_in     = state_ff;
      keep_in      = keep_ff;
      aff_in       = aff_ff;
      seen_in      = seen_ff;
      kept_in      = kept_ff;
      frac_in      = frac_ff;
      resc_in      = resc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && head.last) begin
               q_pop   = 1'b1;
               keep_in = head.keep;
               aff_in  = head.affected;
               seen_in = head.seen;
               kept_in = head_kept;
               if (head.zero_all || (head.seen == '0)) begin
                  frac_in  = '0;
                  resc_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {head_kept, {sbem_pkg::Q16_SHIFT{1'b0}}};
                  div_req.divisor  = head.seen;
                  state_in         = ST_FRAC;
               end
            end else if (!q_empty && out_free) begin
               // Ordinary point: straight to the result register.
               q_pop        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_data_in  = {{(DATA_W-1){1'b0}}, head.keep};
            end
         end
         ST_FRAC: begin
            if (div_rsp.done) begin
               frac_in = div_rsp.quotient[FRAC_W-1:0];
               if (kept_ff == '0) begin
                  resc_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {seen_ff, {sbem_pkg::Q16_SHIFT{1'b0}}};
                  div_req.divisor  = kept_ff;
                  state_in         = ST_RESC;
               end
            end
         end
         ST_RESC: begin
            if (div_rsp.done) begin
               resc_in  = (div_rsp.quotient > sbem_pkg::DIV_W'(sbem_pkg::RESCALE_MAX))
                          ? sbem_pkg::RESCALE_MAX : div_rsp.quotient[RESC_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {resc_ff, frac_ff, aff_ff, keep_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      keep_ff     <= keep_in;
      aff_ff      <= aff_in;
      seen_ff     <= seen_in;
      kept_ff     <= kept_in;
      frac_ff     <= frac_in;
      resc_ff     <= resc_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/spectral_band_excision_mask_top.sv
// Ordinary points: front-end stage register, queue, then result register; one item per cycle
// while the output takes items and the back end is idle. The last point of a channel holds
// the back end for up to two 29-step divisions in the shared bit-serial divider.
// Queued points keep being accepted while it runs, until the 4-entry queue fills.
// Synchronous active-high reset clears all handshake state and the channel
// counts, and sets exclusion mode with both band edges at zero.
module spectral_band_excision_mask_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sbem_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sbem_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sky_freq_hz[39:0], chan_bandwidth_hz[73:40], point_offset_hz[109:74], zero pad
   input  logic [sbem_pkg::REQ_DATA_W-1:0]       req_tdata,
   // lower_sideband
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // keep_point[0], channel_affected[1], used_fraction_q16[18:2], rescale_q16[47:19]
   output logic [sbem_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast
);

`include "spectral_band_excision_mask_top_assert.svh"

   localparam int SKY_LO = 0;
   localparam int BW_LO  = SKY_LO + sbem_pkg::FREQ_W;
   localparam int OFF_LO = BW_LO + sbem_pkg::BW_W;

   sbem_pkg::cfg_type     cfg_ff, cfg_in;
   sbem_pkg::q_entry_type q_entry, q_head;
   sbem_pkg::div_req_type div_req;
   sbem_pkg::div_rsp_type div_rsp;
   logic                  q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sbem_pkg::CSR_EXCLUDE_MODE: cfg_in.exclude_mode = csr_data[0];
            sbem_pkg::CSR_BAND_LOW:     cfg_in.band_low_hz  = csr_data;
            sbem_pkg::CSR_BAND_HIGH:    cfg_in.band_high_hz = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exclude_mode <= 1'b1;
         cfg_ff.band_low_hz  <= '0;
         cfg_ff.band_high_hz <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbem_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .sky_freq_hz       (req_tdata[SKY_LO +: sbem_pkg::FREQ_W]),
      .chan_bandwidth_hz (req_tdata[BW_LO +: sbem_pkg::BW_W]),
      .lower_sideband    (req_tuser),
      .point_offset_hz   (req_tdata[OFF_LO +: sbem_pkg::OFF_W]),
      .last_point        (req_tlast),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_entry           (q_entry)
   );

   sbem_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   sbem_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   sbem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_last  (rsp_tlast),
      .rsp_data  (rsp_tdata)
   );

   // The front end must never push into a full queue nor the back end pop an empty one.
   `SBEM_ASSERT_IMPL(a_no_overflow, q_push, !q_full, "queue push while full")
   `SBEM_ASSERT_IMPL(a_no_underflow, q_pop, !q_empty, "queue pop while empty")
   // A point that does not close a channel carries no channel results.
   `SBEM_ASSERT_IMPL(a_mid_channel_clean, rsp_tvalid && !rsp_tlast,
      rsp_tdata[sbem_pkg::RSP_DATA_W-1:1] == '0, "channel result on a mid-channel item")
   // A divider result never arrives straight after a start; it comes only while the back end waits.
   `SBEM_ASSERT_NEXT(a_div_one_shot, div_req.start, !div_rsp.done,
      "divider finished right after a start")

endmodule

// File: test/band_mask_checker.sv
// Checker for the spectral band excision mask: follows the register writes and the
// point items, predicts each result item and compares it with what the block returns.
// Depends on sbem_pkg for widths, register indexes and the rescale ceiling.
module band_mask_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [sbem_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbem_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // sky_freq_hz, chan_bandwidth_hz, point_offset_hz, zero pad
   input  logic [sbem_pkg::REQ_DATA_W-1:0]   req_tdata,
   // lower_sideband
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // keep_point, channel_affected, used_fraction_q16, rescale_q16
   input  logic [sbem_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbem_pkg::*;

   localparam longint unsigned Q16_ONE = 64'd65536;
   localparam int REPORT_CAP = 30;

   typedef struct packed {
      logic              keep;
      logic              done;
      logic              affected;
      logic [FRAC_W-1:0] frac;
      logic [RESC_W-1:0] resc;
   } verdict_t;

   logic              excl_mode;
   logic [FREQ_W-1:0] band_lo;
   logic [FREQ_W-1:0] band_hi;
   int unsigned       cnt_seen;
   int unsigned       cnt_zeroed;
   verdict_t          expected_verdicts[$];
   int                errors = 0;

   // Decides keep or zero for one point and, on the channel's last point, the
   // kept fraction and the weight rescale factor.
   function automatic verdict_t judge_point(logic [FREQ_W-1:0] sky, logic [BW_W-1:0] bw,
         logic lsb, logic signed [OFF_W-1:0] off, logic last);
      longint s, b, o, lo, hi, ch_lo, ch_hi, f;
      logic overlap, zap;
      longint unsigned seen, kept, ratio;
      verdict_t v;
      s = sky;
      b = bw;
      o = off;
      lo = band_lo;
      hi = band_hi;
      if (lsb) begin
         ch_lo = s - b;
         ch_hi = s;
         f = s - o;
      end else begin
         ch_lo = s;
         ch_hi = s + b;
         f = s + o;
      end
      overlap = (ch_lo <= hi) && (lo <= ch_hi);
      if (excl_mode)
         zap = overlap && (lo < f) && (f < hi);
      else
         zap = !overlap || (f < lo) || (f > hi);
      // Past the count ceiling a point is still judged but no longer counted.
      if (cnt_seen < MAX_POINTS) begin
         cnt_seen++;
         if (zap)
            cnt_zeroed++;
      end
      v = '0;
      v.keep = !zap;
      v.done = last;
      if (last) begin
         seen = cnt_seen;
         kept = seen - cnt_zeroed;
         v.affected = overlap || !excl_mode;
         // An inclusion channel outside the band reports zero fraction and factor.
         if (excl_mode || overlap) begin
            if (seen != 0)
               v.frac = FRAC_W'(kept * Q16_ONE / seen);
            if (kept != 0) begin
               ratio = seen * Q16_ONE / kept;
               v.resc = (ratio > RESCALE_MAX) ? RESCALE_MAX : RESC_W'(ratio);
            end
         end
         cnt_seen = 0;
         cnt_zeroed = 0;
      end
      return v;
   endfunction

   task automatic compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_t want, got;
      if (reset) begin
         excl_mode = 1'b1;
         band_lo = '0;
         band_hi = '0;
         cnt_seen = 0;
         cnt_zeroed = 0;
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXCLUDE_MODE: excl_mode = csr_data[0];
               CSR_BAND_LOW:     band_lo = csr_data[FREQ_W-1:0];
               CSR_BAND_HIGH:    band_hi = csr_data[FREQ_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_verdicts.push_back(judge_point(req_tdata[FREQ_W-1:0],
                  req_tdata[FREQ_W+BW_W-1:FREQ_W], req_tuser,
                  req_tdata[FREQ_W+BW_W+OFF_W-1:FREQ_W+BW_W], req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got.keep = rsp_tdata[0];
            got.done = rsp_tlast;
            got.affected = rsp_tdata[1];
            got.frac = rsp_tdata[2 +: FRAC_W];
            got.resc = rsp_tdata[2 + FRAC_W +: RESC_W];
            if (expected_verdicts.size() == 0) begin
               errors++;
               if (errors <= REPORT_CAP)
                  $display("%0t: result item with none expected, expected nothing, actual %h",
                        $time, got);
            end else begin
               want = expected_verdicts.pop_front();
               compare_field("keep_point", want.keep, got.keep);
               compare_field("channel_done", want.done, got.done);
               compare_field("channel_affected", want.affected, got.affected);
               compare_field("used_fraction_q16", want.frac, got.frac);
               compare_field("rescale_q16", want.resc, got.resc);
            end
         end
      end
      fail_count <= errors;
      pending <= expected_verdicts.size();
   end

endmodule

// File: test/tb.sv
// Top of the band excision mask testbench: clock, reset, point and register stimulus,
// output back-pressure, watchdog and verdict.
// Depends on sbem_pkg, spectral_band_excision_mask_top and band_mask_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sbem_pkg::*;

   // Index with no register behind it; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint FREQ_MAX = (64'sd1 <<< FREQ_W) - 1;
   localparam longint BW_MAX = (64'sd1 <<< BW_W) - 1;
   localparam longint OFF_MAX = (64'sd1 <<< (OFF_W - 1)) - 1;
   localparam longint OFF_MIN = -(64'sd1 <<< (OFF_W - 1));
   localparam int SETTLE_CYCLES = 70;
   localparam int LONG_STALL = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_POINTS = 1420;
   localparam int CALM_POINTS = 1150;
   localparam int PHASE_POINTS = 110;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   int                    fail_count;
   int                    pending;

   logic   calm;
   int     idle_pct;
   int     stall_ask;
   int     quiet_cycles = 0;
   int     points_sent = 0;
   int     channels_sent = 0;
   int     settings_used = 0;
   longint band_lo = 0;
   longint band_hi = 0;

   spectral_band_excision_mask_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   band_mask_checker mask_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint upto(longint n);
      longint unsigned r;
      r = {$urandom, $urandom};
      return longint'(r % (n + 1));
   endfunction

   function automatic longint clamp(longint v, longint top);
      return (v < 0) ? 0 : ((v > top) ? top : v);
   endfunction

   // Offers one point item and returns at the edge that accepts it, valid left high.
   task automatic offer_point(longint sky, longint bw, logic lsb, longint off, logic last);
      int gap;
      if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - FREQ_W - BW_W - OFF_W){1'b0}},
                    off[OFF_W-1:0], bw[BW_W-1:0], sky[FREQ_W-1:0]};
      req_tuser <= lsb;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      points_sent++;
      if (last)
         channels_sent++;
   endtask

   // Waits until every expected result has come back, then lets a division finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_band(logic excl, longint lo, longint hi);
      logic [CSR_IDX_W-1:0]  idx[4];
      logic [CSR_DATA_W-1:0] val[4];
      drain();
      idx = '{CSR_SPARE, CSR_EXCLUDE_MODE, CSR_BAND_LOW, CSR_BAND_HIGH};
      val = '{CSR_DATA_W'(upto(FREQ_MAX)), CSR_DATA_W'(excl), CSR_DATA_W'(lo),
              CSR_DATA_W'(hi)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      band_lo = lo;
      band_hi = hi;
      settings_used++;
   endtask

   // Output side: random short stalls, plus one long hold-off when asked.
   initial begin : rsp_side
      int stalls_done;
      stalls_done = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_ask != stalls_done) begin
            stalls_done++;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
            (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      longint lo, hi, span, bw, ch_lo, sky, f, off;
      logic   lsb, excl;
      int     n, pick, phase, random_base, target;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_EXCLUDE_MODE;
      csr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      req_tlast <= 1'b0;
      calm <= 1'b0;
      idle_pct <= 20;
      stall_ask <= 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: exclusion with both edges at zero, field extremes.
      offer_point(0, 0, 1'b0, 0, 1'b1);
      offer_point(FREQ_MAX, BW_MAX, 1'b1, OFF_MIN, 1'b0);
      offer_point(FREQ_MAX, BW_MAX, 1'b1, OFF_MAX, 1'b1);

      // Exclusion: band edges themselves are kept, a lone zeroed point keeps nothing.
      program_band(1'b1, 1000, 2000);
      offer_point(1500, 100, 1'b0, -500, 1'b0);
      offer_point(1500, 100, 1'b0, -499, 1'b0);
      offer_point(1500, 100, 1'b0, 0, 1'b0);
      offer_point(1500, 100, 1'b0, 499, 1'b0);
      offer_point(1500, 100, 1'b0, 500, 1'b0);
      offer_point(1500, 100, 1'b0, 600, 1'b1);
      offer_point(1500, 100, 1'b0, 0, 1'b1);

      // Inclusion: lower sideband channel, a channel off the band, and a channel
      // whose sky frequency changes before its last point.
      program_band(1'b0, 1000, 2000);
      offer_point(1050, 100, 1'b1, 0, 1'b0);
      offer_point(1050, 100, 1'b1, 51, 1'b0);
      offer_point(1050, 100, 1'b1, 50, 1'b0);
      offer_point(1050, 100, 1'b1, -950, 1'b1);
      offer_point(5000, 10, 1'b0, 0, 1'b0);
      offer_point(5000, 10, 1'b0, 10, 1'b1);
      offer_point(5000, 10, 1'b0, 0, 1'b0);
      offer_point(1500, 10, 1'b0, 0, 1'b1);

      // Reversed band edges in both modes.
      program_band(1'b0, 2000, 1000);
      offer_point(500, 2000, 1'b0, 0, 1'b0);
      offer_point(500, 2000, 1'b0, 1500, 1'b1);
      program_band(1'b1, 2000, 1000);
      offer_point(500, 2000, 1'b0, 0, 1'b0);
      offer_point(500, 2000, 1'b0, 1500, 1'b1);

      // Widest band at the top of the frequency range.
      program_band(1'b1, 0, FREQ_MAX);
      offer_point(FREQ_MAX, 0, 1'b0, -1, 1'b0);
      offer_point(FREQ_MAX, 0, 1'b0, 0, 1'b1);

      // A channel with two kept points among zeroed ones, which pushes the
      // rescale factor well above one.
      program_band(1'b0, 1000000, 2000000);
      offer_point(1500000, 100, 1'b0, 0, 1'b0);
      for (int i = 0; i < 4; i++)
         offer_point(1500000, 100, 1'b0, -1000000, 1'b0);
      offer_point(1500000, 100, 1'b0, 0, 1'b1);

      random_base = points_sent;
      phase = 0;
      while (points_sent - random_base < RANDOM_POINTS) begin
         excl = 1'($urandom_range(0, 1));
         case (phase)
            0: begin
               lo = FREQ_MAX;
               hi = FREQ_MAX;
               excl = 1'b0;
            end
            1: begin
               lo = 0;
               hi = FREQ_MAX;
            end
            2: begin
               lo = 0;
               hi = 0;
               excl = 1'b0;
            end
            default: begin
               lo = upto(FREQ_MAX);
               case ($urandom_range(0, 3))
                  0: hi = lo + upto(1000);
                  1: hi = lo + upto(1 << 24);
                  2: hi = lo + upto(BW_MAX);
                  default: hi = lo - upto(1 << 24);
               endcase
               hi = clamp(hi, FREQ_MAX);
            end
         endcase
         program_band(excl, lo, hi);
         calm <= (points_sent - random_base >= CALM_POINTS);
         idle_pct <= (phase % 4 == 1) ? 0 : $urandom_range(10, 40);
         // Hold the output off long enough for the block to stop taking points.
         if (phase == 3)
            stall_ask <= stall_ask + 1;

         lo = (band_lo < band_hi) ? band_lo : band_hi;
         hi = (band_lo < band_hi) ? band_hi : band_lo;
         span = hi - lo;
         target = points_sent - random_base + PHASE_POINTS;
         while (points_sent - random_base < target) begin
            if ($urandom_range(0, 99) >= 85) begin
               // Stray point: all fields random, possibly breaking into a channel.
               offer_point(upto(FREQ_MAX), upto(BW_MAX), 1'($urandom_range(0, 1)),
                     OFF_MIN + upto(OFF_MAX - OFF_MIN), 1'($urandom_range(0, 1)));
            end else begin
               lsb = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 3))
                  0: bw = upto(span + 16);
                  1: bw = upto(1000);
                  2: bw = upto(BW_MAX);
                  default: bw = $urandom_range(0, 1) ? BW_MAX : 0;
               endcase
               bw = clamp(bw, BW_MAX);
               case ($urandom_range(0, 5))
                  0: ch_lo = lo + upto(span) - upto(bw);
                  1: ch_lo = lo - bw - 1 - upto(1000);
                  2: ch_lo = hi + 1 + upto(1000);
                  3: ch_lo = lo - bw;
                  4: ch_lo = hi;
                  default: ch_lo = upto(FREQ_MAX);
               endcase
               sky = clamp(lsb ? ch_lo + bw : ch_lo, FREQ_MAX);
               ch_lo = lsb ? sky - bw : sky;
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
               for (int i = 0; i < n; i++) begin
                  pick = $urandom_range(0, 7);
                  case (pick)
                     0: f = band_lo;
                     1: f = band_hi;
                     2: f = band_lo + ($urandom_range(0, 1) ? 1 : -1);
                     3: f = band_hi + ($urandom_range(0, 1) ? 1 : -1);
                     4, 5: f = ch_lo + upto(bw);
                     6: f = lo + upto(span);
                     default: f = sky;
                  endcase
                  off = lsb ? sky - f : f - sky;
                  if (pick == 7)
                     off = OFF_MIN + upto(OFF_MAX - OFF_MIN);
                  off = (off < OFF_MIN) ? OFF_MIN : ((off > OFF_MAX) ? OFF_MAX : off);
                  offer_point(sky, bw, lsb, off, i == n - 1);
               end
            end
         end
         phase++;
      end

      drain();
      $display("Run covered %0d points in %0d channels under %0d band settings,", points_sent,
            channels_sent, settings_used);
      $display("including reversed band edges, field extremes and a %0d-cycle output stall.",
            LONG_STALL);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
